/* src/wpds_pkg.sv */
// Shared types and constants for the water proximity dilation store.
// No dependencies; imported by the top level, wpds_clay_mem and wpds_window.
`default_nettype none

package wpds_pkg;

   localparam int TILE_W     = 8;
   localparam int KIND_W     = 2;
   localparam int CLAY_W     = 16;
   localparam int CSR_DATA_W = 9;
   localparam int CSR_IDX_W  = 1;
   // signed working width for window coordinates and map extents
   localparam int COORD_W    = 11;

   localparam logic [CLAY_W-1:0] CLAY_FULL = 16'd65000;

   typedef enum logic [KIND_W-1:0] {
      KIND_LOAD    = 2'd0,
      KIND_COMPUTE = 2'd1,
      KIND_DEPLETE = 2'd2,
      KIND_READ    = 2'd3
   } kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MAP_WIDTH  = 1'b0,
      CSR_MAP_HEIGHT = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_WRITE
   } state_type;

   // control from the sequencer to the window accumulator
   typedef struct packed {
      logic clear;
      logic en;
      logic row_ok;
      logic is_center;
   } win_ctl_type;

endpackage

`default_nettype wire

/* src/water_proximity_dilation_store.sv */
// Top level: sequencer, map registers, result register and the two stores.
// Depends on wpds_pkg, wpds_mask_mem, wpds_clay_mem and wpds_window.
//
//  channel | direction | signals
//  csr     | in        | csr_we, csr_index, csr_wdata (write only, no wait)
//  req     | in        | req_valid/req_ready, kind, tile_x, tile_y, is_water, amount
//  rsp     | out       | rsp_valid/rsp_ready, clay_value
//
// Load, deplete, read and any tile outside the map go from idle straight to
// the write stage: the transfer issues the clay store read, the write stage
// writes back and loads rsp. Compute reads one mask row per window row on
// the single mask read port in the scan state, then passes drain and write.
// After reset a clearing pass zeroes both stores; req_ready stays low
// meanwhile. A stalled rsp holds the write stage; one new item may be
// accepted while a result waits.
`default_nettype none

module water_proximity_dilation_store #(
   parameter int GRID_SIDE   = 256,
   parameter int NEAR_RADIUS = 2
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_we,
   input  wire logic [wpds_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [wpds_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic [wpds_pkg::KIND_W-1:0]     req_kind,
   input  wire logic [wpds_pkg::TILE_W-1:0]     req_tile_x,
   input  wire logic [wpds_pkg::TILE_W-1:0]     req_tile_y,
   input  wire logic                            req_is_water,
   input  wire logic [wpds_pkg::CLAY_W-1:0]     req_amount,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic      [wpds_pkg::CLAY_W-1:0]     rsp_clay_value
);
   import wpds_pkg::*;

   localparam int ROW_W  = $clog2(GRID_SIDE);
   localparam int ADDR_W = 2*ROW_W;
   localparam int WIN    = 2*NEAR_RADIUS + 1;
   localparam int K_W    = (WIN > 2) ? $clog2(WIN) : 1;

   state_type state_ff, state_in;

   logic [CSR_DATA_W-1:0] map_width_ff, map_height_ff;
   logic [COORD_W-1:0]    w_ext, h_ext;

   kind_type          kind_ff;
   logic [TILE_W-1:0] x_ff, y_ff;
   logic              wet_ff;
   logic [CLAY_W-1:0] amount_ff;
   logic              off_ff;

   logic [K_W-1:0]    k_ff;
   logic              pend_ff, pend_ok_ff, pend_ctr_ff;
   logic [ADDR_W-1:0] clr_cnt_ff;

   logic              rsp_valid_ff;
   logic [CLAY_W-1:0] rsp_value_ff;

   logic               accept, in_map, go;
   logic [COORD_W-1:0] py;
   logic               row_ok;
   logic               clay_we, mask_bit_we;
   logic [ADDR_W-1:0]  item_addr, req_addr;
   logic [CLAY_W-1:0]  clay_rd, wr_value;
   logic [GRID_SIDE-1:0] row_data;
   logic               near, center;
   win_ctl_type        win_ctl;

   // extents clipped to the grid
   assign w_ext = (COORD_W'(map_width_ff) > COORD_W'(GRID_SIDE))
                  ? COORD_W'(GRID_SIDE) : COORD_W'(map_width_ff);
   assign h_ext = (COORD_W'(map_height_ff) > COORD_W'(GRID_SIDE))
                  ? COORD_W'(GRID_SIDE) : COORD_W'(map_height_ff);

   assign accept = req_valid && req_ready;
   assign in_map = (COORD_W'(req_tile_x) < w_ext) && (COORD_W'(req_tile_y) < h_ext);
   assign go     = !rsp_valid_ff || rsp_ready;

   wire [COORD_W-1:0] req_x_w = COORD_W'(req_tile_x);
   wire [COORD_W-1:0] req_y_w = COORD_W'(req_tile_y);
   wire [COORD_W-1:0] x_w     = COORD_W'(x_ff);
   wire [COORD_W-1:0] y_w     = COORD_W'(y_ff);

   assign req_addr  = {req_y_w[ROW_W-1:0], req_x_w[ROW_W-1:0]};
   assign item_addr = {y_w[ROW_W-1:0], x_w[ROW_W-1:0]};

   assign py     = y_w + COORD_W'(k_ff) - COORD_W'(NEAR_RADIUS);
   assign row_ok = !py[COORD_W-1] && (py < h_ext);

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         map_width_ff  <= CSR_DATA_W'(256);
         map_height_ff <= CSR_DATA_W'(256);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_MAP_WIDTH:  map_width_ff  <= csr_wdata;
            CSR_MAP_HEIGHT: map_height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: if (clr_cnt_ff == '1) state_in = ST_IDLE;
         ST_IDLE: begin
            if (req_valid) begin
               state_in = (in_map && kind_type'(req_kind) == KIND_COMPUTE)
                          ? ST_SCAN : ST_WRITE;
            end
         end
         ST_SCAN:  if (k_ff == K_W'(WIN-1)) state_in = ST_DRAIN;
         ST_DRAIN: state_in = ST_WRITE;
         ST_WRITE: if (go) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_ready         = 1'b0;
      clay_we           = 1'b0;
      mask_bit_we       = 1'b0;
      win_ctl.clear     = accept;
      win_ctl.en        = pend_ff;
      win_ctl.row_ok    = pend_ok_ff;
      win_ctl.is_center = pend_ctr_ff;
      unique case (state_ff)
         ST_CLEAR: clay_we = 1'b1;
         ST_IDLE:  req_ready = 1'b1;
         ST_WRITE: begin
            clay_we     = go && !off_ff && kind_ff != KIND_READ;
            mask_bit_we = go && !off_ff && kind_ff == KIND_LOAD;
         end
         default: ;
      endcase
   end

   always_comb begin
      unique case (kind_ff)
         KIND_LOAD:    wr_value = '0;
         KIND_COMPUTE: wr_value = (!center && near) ? CLAY_FULL : '0;
         KIND_DEPLETE: wr_value = (clay_rd > amount_ff) ? clay_rd - amount_ff : '0;
         KIND_READ:    wr_value = clay_rd;
         default:      wr_value = clay_rd;
      endcase
      if (off_ff) begin
         wr_value = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         k_ff         <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_CLEAR) begin
            clr_cnt_ff <= clr_cnt_ff + 1'b1;
         end
         if (accept) begin
            k_ff <= '0;
         end else if (state_ff == ST_SCAN && k_ff != K_W'(WIN-1)) begin
            k_ff <= k_ff + 1'b1;
         end
         pend_ff <= (state_ff == ST_SCAN);
         if (state_ff == ST_WRITE && go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      pend_ok_ff  <= row_ok;
      pend_ctr_ff <= (k_ff == K_W'(NEAR_RADIUS));
      if (accept) begin
         kind_ff   <= kind_type'(req_kind);
         x_ff      <= req_tile_x;
         y_ff      <= req_tile_y;
         wet_ff    <= req_is_water;
         amount_ff <= req_amount;
         off_ff    <= !in_map;
      end
      if (state_ff == ST_WRITE && go) begin
         rsp_value_ff <= wr_value;
      end
   end

   wpds_mask_mem #(
      .GRID_SIDE (GRID_SIDE)
   ) u_mask (
      .clock   (clock),
      .clr_we  (state_ff == ST_CLEAR),
      .clr_row (clr_cnt_ff[ADDR_W-1 -: ROW_W]),
      .bit_we  (mask_bit_we),
      .bit_row (y_w[ROW_W-1:0]),
      .bit_col (x_w[ROW_W-1:0]),
      .bit_val (wet_ff),
      .rd_row  (py[ROW_W-1:0]),
      .rd_data (row_data)
   );

   wpds_clay_mem #(
      .GRID_SIDE (GRID_SIDE)
   ) u_clay (
      .clock (clock),
      .we    (clay_we),
      .waddr ((state_ff == ST_CLEAR) ? clr_cnt_ff : item_addr),
      .wdata ((state_ff == ST_CLEAR) ? '0 : wr_value),
      .re    (accept),
      .raddr (req_addr),
      .rdata (clay_rd)
   );

   wpds_window #(
      .GRID_SIDE   (GRID_SIDE),
      .NEAR_RADIUS (NEAR_RADIUS)
   ) u_window (
      .clock     (clock),
      .ctl       (win_ctl),
      .row_data  (row_data),
      .tile_x    (x_ff),
      .width_ext (w_ext),
      .near      (near),
      .center    (center)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_clay_value = rsp_value_ff;

   a_rsp_from_write: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_WRITE))
      else $error("result raised outside the write stage");

   a_no_store_write_in_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN || state_ff == ST_DRAIN) |-> !clay_we && !mask_bit_we)
      else $error("store written during window scan");

   a_write_returns_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WRITE && go) |=> state_ff == ST_IDLE)
      else $error("write stage did not return to idle");

   a_scan_count_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> k_ff <= K_W'(WIN-1))
      else $error("window row counter out of range");

   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLEAR |-> !req_ready)
      else $error("input taken during clearing pass");

endmodule

`default_nettype wire

/* src/wpds_mask_mem.sv */
// Water mask memory: one row of the grid per word, registered read.
// Does not use wpds_pkg; sized by the GRID_SIDE parameter alone.
`default_nettype none

module wpds_mask_mem #(
   parameter int GRID_SIDE = 256
) (
   input  wire logic                         clock,
   input  wire logic                         clr_we,
   input  wire logic [$clog2(GRID_SIDE)-1:0] clr_row,
   input  wire logic                         bit_we,
   input  wire logic [$clog2(GRID_SIDE)-1:0] bit_row,
   input  wire logic [$clog2(GRID_SIDE)-1:0] bit_col,
   input  wire logic                         bit_val,
   input  wire logic [$clog2(GRID_SIDE)-1:0] rd_row,
   output logic      [GRID_SIDE-1:0]         rd_data
);

   logic [GRID_SIDE-1:0] mem [GRID_SIDE];

   always_ff @(posedge clock) begin
      if (clr_we) begin
         mem[clr_row] <= '0;
      end else if (bit_we) begin
         mem[bit_row][bit_col] <= bit_val;
      end
   end

   always_ff @(posedge clock) begin
      rd_data <= mem[rd_row];
   end

endmodule

`default_nettype wire

/* src/wpds_clay_mem.sv */
// Clay value memory: one 16-bit entry per tile, registered read.
// Uses CLAY_W from wpds_pkg.
`default_nettype none

module wpds_clay_mem #(
   parameter int GRID_SIDE = 256
) (
   input  wire logic                           clock,
   input  wire logic                           we,
   input  wire logic [2*$clog2(GRID_SIDE)-1:0] waddr,
   input  wire logic [wpds_pkg::CLAY_W-1:0]    wdata,
   input  wire logic                           re,
   input  wire logic [2*$clog2(GRID_SIDE)-1:0] raddr,
   output logic      [wpds_pkg::CLAY_W-1:0]    rdata
);
   import wpds_pkg::*;

   logic [CLAY_W-1:0] mem [GRID_SIDE*GRID_SIDE];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // read data holds until the next read
   always_ff @(posedge clock) begin
      if (re) begin
         rdata <= mem[raddr];
      end
   end

endmodule

`default_nettype wire

/* src/wpds_window.sv */
// Window accumulator: ORs the in-map window bits of one mask row per step
// and captures the center tile's flag. Uses wpds_pkg types and widths.
`default_nettype none

module wpds_window #(
   parameter int GRID_SIDE   = 256,
   parameter int NEAR_RADIUS = 2
) (
   input  wire logic                         clock,
   input  wire wpds_pkg::win_ctl_type        ctl,
   input  wire logic [GRID_SIDE-1:0]         row_data,
   input  wire logic [wpds_pkg::TILE_W-1:0]  tile_x,
   input  wire logic [wpds_pkg::COORD_W-1:0] width_ext,
   output logic                              near,
   output logic                              center
);
   import wpds_pkg::*;

   localparam int ROW_W = $clog2(GRID_SIDE);
   localparam int WIN   = 2*NEAR_RADIUS + 1;

   logic [COORD_W-1:0] cx;
   logic [WIN-1:0]     hit;
   logic               acc_ff, acc_in;
   logic               center_ff, center_in;

   assign cx = COORD_W'(tile_x);

   always_comb begin
      logic [COORD_W-1:0] px;
      for (int d = 0; d < WIN; d++) begin
         px = cx + COORD_W'(d) - COORD_W'(NEAR_RADIUS);
         // sign bit set means left of column zero
         hit[d] = !px[COORD_W-1] && (px < width_ext) && row_data[px[ROW_W-1:0]];
      end
   end

   always_comb begin
      acc_in    = acc_ff;
      center_in = center_ff;
      if (ctl.clear) begin
         acc_in    = 1'b0;
         center_in = 1'b0;
      end else if (ctl.en && ctl.row_ok) begin
         acc_in = acc_ff | (|hit);
         if (ctl.is_center) begin
            center_in = row_data[cx[ROW_W-1:0]];
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff    <= acc_in;
      center_ff <= center_in;
   end

   assign near   = acc_ff;
   assign center = center_ff;

endmodule

`default_nettype wire
